/* design/escaped_frame_receiver_macros.svh */
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_MACROS_SVH

// Implication that is checked only outside reset.
`define EFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is checked at every edge, reset included.
`define EFR_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/efr_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Framing symbols, event codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efr_pkg;

   localparam logic [7:0] SymStart = 8'hAA;
   localparam logic [7:0] SymEnd   = 8'hCC;
   localparam logic [7:0] SymEsc   = 8'hBB;
   localparam logic [7:0] EscStart = 8'h55;
   localparam logic [7:0] EscEsc   = 8'h44;
   localparam logic [7:0] EscEnd   = 8'h33;

   localparam logic [2:0] EvPayload = 3'd0;
   localparam logic [2:0] EvGood    = 3'd1;
   localparam logic [2:0] EvBadSum  = 3'd2;
   localparam logic [2:0] EvAbort   = 3'd3;
   localparam logic [2:0] EvBadEsc  = 3'd4;

   localparam logic [15:0] ErrMax = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [7:0]  payload_byte;
      logic [15:0] error_total;
   } rsp_type;

endpackage

/* design/escaped_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame deframer with a trailing additive checksum.
// ----------------------------------------------------------------------------
// Received bytes enter on the req_ channel, one per transfer. Each transfer
// produces zero or one event on the rsp_ channel: a payload byte, a good or
// bad frame end, an aborted frame or a bad escape, with the running count of
// consecutive errors. A decoded byte is released as payload only when the
// next decoded byte arrives, so the checksum byte is never shown as payload.
// The decode is one short pass over the frame state; the event is registered
// before it appears on the rsp_ channel. One byte is taken in every cycle
// while req_stall is low. When rsp_stall holds an event in the output
// register, one more event can be parked in a skid register; req_stall rises
// only while that skid register is full, and falls the cycle after the output
// side moves again. Synchronous reset closes any open frame, clears the
// checksum state and the error count, and empties both event registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_error_total
);

   logic        in_frame_ff, in_frame_in;
   logic        escape_ff, escape_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_value_ff, held_value_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] err_ff, err_in;

   logic              out_valid_ff, skid_valid_ff;
   efr_pkg::rsp_type  out_ff, skid_ff;

   logic              accept;
   logic              out_free;
   logic              ev_valid;
   efr_pkg::rsp_type  ev;
   logic              push;
   logic [7:0]        push_byte;
   logic [15:0]       err_bumped;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign err_bumped = (err_ff == efr_pkg::ErrMax) ? err_ff : err_ff + 16'd1;

   always_comb begin
      in_frame_in   = in_frame_ff;
      escape_in     = escape_ff;
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      sum_in        = sum_ff;
      err_in        = err_ff;
      ev_valid      = 1'b0;
      ev.event_kind = efr_pkg::EvPayload;
      ev.payload_byte = 8'd0;
      push          = 1'b0;
      push_byte     = req_rx_byte;
      if (req_rx_byte == efr_pkg::SymStart) begin
         in_frame_in   = 1'b1;
         escape_in     = 1'b0;
         held_valid_in = 1'b0;
         held_value_in = 8'd0;
         sum_in        = 8'd0;
         if (in_frame_ff) begin
            err_in        = err_bumped;
            ev_valid      = 1'b1;
            ev.event_kind = efr_pkg::EvAbort;
         end
      end else if (in_frame_ff) begin
         if (req_rx_byte == efr_pkg::SymEnd) begin
            in_frame_in   = 1'b0;
            escape_in     = 1'b0;
            held_valid_in = 1'b0;
            held_value_in = 8'd0;
            sum_in        = 8'd0;
            ev_valid      = 1'b1;
            if (held_valid_ff && (held_value_ff == sum_ff)) begin
               err_in        = 16'd0;
               ev.event_kind = efr_pkg::EvGood;
            end else begin
               err_in        = err_bumped;
               ev.event_kind = efr_pkg::EvBadSum;
            end
         end else if (!escape_ff) begin
            if (req_rx_byte == efr_pkg::SymEsc) begin
               escape_in = 1'b1;
            end else begin
               push = 1'b1;
            end
         end else begin
            escape_in = 1'b0;
            priority if (req_rx_byte == efr_pkg::EscStart) begin
               push      = 1'b1;
               push_byte = efr_pkg::SymStart;
            end else if (req_rx_byte == efr_pkg::EscEsc) begin
               push      = 1'b1;
               push_byte = efr_pkg::SymEsc;
            end else if (req_rx_byte == efr_pkg::EscEnd) begin
               push      = 1'b1;
               push_byte = efr_pkg::SymEnd;
            end else begin
               err_in        = err_bumped;
               ev_valid      = 1'b1;
               ev.event_kind = efr_pkg::EvBadEsc;
            end
         end
      end
      if (push) begin
         held_value_in = push_byte;
         held_valid_in = 1'b1;
         if (held_valid_ff) begin
            sum_in          = sum_ff + held_value_ff;
            ev_valid        = 1'b1;
            ev.event_kind   = efr_pkg::EvPayload;
            ev.payload_byte = held_value_ff;
         end
      end
      ev.error_total = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         escape_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         held_value_ff <= 8'd0;
         sum_ff        <= 8'd0;
         err_ff        <= 16'd0;
      end else if (accept) begin
         in_frame_ff   <= in_frame_in;
         escape_ff     <= escape_in;
         held_valid_ff <= held_valid_in;
         held_value_ff <= held_value_in;
         sum_ff        <= sum_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && ev_valid;
         end
      end else if (accept && ev_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : ev;
      end
      if (!out_free && accept && ev_valid) begin
         skid_ff <= ev;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_ff.event_kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_error_total  = out_ff.error_total;

endmodule

/* design/efr_checker.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Port-level properties of the event channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "escaped_frame_receiver_macros.svh"

module efr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_error_total
);

   `EFR_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)
   `EFR_ASSERT_IMPLY(a_stall_holds, clock, reset, $past(rsp_valid && rsp_stall && !reset), rsp_valid && $stable(rsp_event_kind))
   `EFR_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, rsp_event_kind <= efr_pkg::EvBadEsc)
   `EFR_ASSERT_IMPLY(a_zero_byte, clock, reset, rsp_valid && (rsp_event_kind != efr_pkg::EvPayload), rsp_payload_byte == 8'd0)
   `EFR_ASSERT_IMPLY(a_good_clears, clock, reset, rsp_valid && (rsp_event_kind == efr_pkg::EvGood), rsp_error_total == 16'd0)

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
